>>> src/trsf_pkg.sv
// types and codes for the two-reader shared record fifo
// used by trsf_ctrl, trsf_store and two_reader_shared_fifo_core
package trsf_pkg;

  typedef enum logic [1:0] {
    FUNC_INSERT      = 2'd0,
    FUNC_READ_FIRST  = 2'd1,
    FUNC_READ_SECOND = 2'd2
  } trsf_func_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_DATA = 2'd1,
    ST_FULL    = 2'd2
  } trsf_status_e;

  typedef struct packed {
    logic [15:0] sensor_id;
    logic [31:0] timestamp;
    logic [63:0] value;
  } trsf_rec_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] in_sensor_id;
    logic [31:0] in_timestamp;
    logic [63:0] in_value;
  } trsf_in_t;

  typedef struct packed {
    trsf_status_e status;
    logic [15:0]  out_sensor_id;
    logic [31:0]  out_timestamp;
    logic [63:0]  out_value;
    logic [6:0]   occupancy;
    logic [6:0]   unread_first;
    logic [6:0]   unread_second;
  } trsf_out_t;

  // per-beat result info that travels alongside the store read
  typedef struct packed {
    trsf_status_e status;
    logic         hit;
    logic [6:0]   occupancy;
    logic [6:0]   unread_first;
    logic [6:0]   unread_second;
  } trsf_meta_t;

endpackage

>>> src/trsf_ctrl.sv
// head pointer, fill count and per-reader consumed counts of the shared fifo
// computes store addresses and result info for each accepted beat; uses trsf_pkg
module trsf_ctrl #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [1:0]           func_i,
  output logic                 wr_en_o,
  output logic [AW-1:0]        wr_addr_o,
  output logic                 rd_en_o,
  output logic [AW-1:0]        rd_addr_o,
  output trsf_pkg::trsf_meta_t meta_o
);
  import trsf_pkg::*;

  logic [AW-1:0] oldest_q, oldest_d, oldest_1;
  logic [CW-1:0] count_q, count_d, count_1;
  logic [CW-1:0] cf_q, cf_d, cf_1;
  logic [CW-1:0] cs_q, cs_d, cs_1;
  logic [CW-1:0] mine;
  logic          is_ins, is_rd, rd_first, full, drop, hit;

  // position of the record at offset off from base, wrapping at DEPTH
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [AW:0] p;
    p = {1'b0, base} + (AW + 1)'(off);
    if (p >= (AW + 1)'(DEPTH)) p = p - (AW + 1)'(DEPTH);
    return p[AW-1:0];
  endfunction

  always_comb begin
    is_ins   = 1'b0;
    is_rd    = 1'b0;
    rd_first = 1'b0;
    unique case (func_i)
      FUNC_INSERT:      is_ins = 1'b1;
      FUNC_READ_FIRST: begin
        is_rd    = 1'b1;
        rd_first = 1'b1;
      end
      FUNC_READ_SECOND: is_rd = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    full = (count_q == CW'(DEPTH));
    // head goes once both readers have consumed it
    drop = is_rd && (count_q != '0) && (cf_q != '0) && (cs_q != '0);

    oldest_1 = drop ? slot(oldest_q, CW'(1)) : oldest_q;
    count_1  = count_q - CW'(drop);
    cf_1     = cf_q - CW'(drop);
    cs_1     = cs_q - CW'(drop);

    mine = rd_first ? cf_1 : cs_1;
    hit  = is_rd && (count_q != '0) && (mine < count_1);

    wr_en_o   = accept_i && is_ins && !full;
    wr_addr_o = slot(oldest_q, count_q);
    rd_en_o   = accept_i && hit;
    rd_addr_o = slot(oldest_1, mine);

    oldest_d = oldest_1;
    count_d  = (is_ins && !full) ? count_q + CW'(1) : count_1;
    cf_d     = cf_1 + CW'(hit && rd_first);
    cs_d     = cs_1 + CW'(hit && !rd_first);

    if (is_ins) meta_o.status = full ? ST_FULL : ST_OK;
    else        meta_o.status = hit ? ST_OK : ST_NO_DATA;
    meta_o.hit           = hit;
    meta_o.occupancy     = 7'(count_d);
    meta_o.unread_first  = 7'(CW'(count_d - cf_d));
    meta_o.unread_second = 7'(CW'(count_d - cs_d));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q <= '0;
      count_q  <= '0;
      cf_q     <= '0;
      cs_q     <= '0;
    end else if (accept_i) begin
      oldest_q <= oldest_d;
      count_q  <= count_d;
      cf_q     <= cf_d;
      cs_q     <= cs_d;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("fill count above depth");

  a_first_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cf_q <= count_q)
    else $error("first reader consumed more than held");

  a_second_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cs_q <= count_q)
    else $error("second reader consumed more than held");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |=> count_q == $past(count_q) + CW'(1))
    else $error("accepted insert did not grow the fifo");

  a_read_not_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en_o && rd_en_o))
    else $error("store written and read by the same beat");

endmodule

>>> src/trsf_store.sv
// record storage of the shared fifo: one write port, one registered read port
// uses trsf_pkg for the record type
module trsf_store #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [AW-1:0]       wr_addr_i,
  input  trsf_pkg::trsf_rec_t wr_rec_i,
  input  logic                rd_en_i,
  input  logic [AW-1:0]       rd_addr_i,
  output trsf_pkg::trsf_rec_t rd_rec_o
);
  import trsf_pkg::*;

  trsf_rec_t mem [DEPTH];
  trsf_rec_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_rec_i;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) rd_q <= mem[rd_addr_i];
  end

  assign rd_rec_o = rd_q;

endmodule

>>> src/two_reader_shared_fifo_core.sv
// two-reader shared record fifo: each accepted input beat yields one result beat;
// throughput one beat per cycle unless the output stalls, limited by the single
// read port of the store. stage 1 holds the registered store read and result info,
// stage 2 the result. reset clears head pointer, fill count, both consumed counts
// and valid flags; store contents stay undefined and need no clearing pass.
module two_reader_shared_fifo_core #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  trsf_pkg::trsf_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output trsf_pkg::trsf_out_t out_data_o
);
  import trsf_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic          accept, s1_adv;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  trsf_meta_t    meta, meta_q;
  trsf_rec_t     wr_rec, rd_rec;
  logic          s1_valid_q, s1_valid_d;
  logic          out_valid_q, out_valid_d;
  trsf_out_t     out_q, out_d;

  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign accept     = in_valid_i && in_ready_o;

  assign wr_rec.sensor_id = in_data_i.in_sensor_id;
  assign wr_rec.timestamp = in_data_i.in_timestamp;
  assign wr_rec.value     = in_data_i.in_value;

  trsf_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .func_i    (in_data_i.func),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .meta_o    (meta)
  );

  trsf_store #(.DEPTH(DEPTH)) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_rec_i  (wr_rec),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_rec_o  (rd_rec)
  );

  always_comb begin
    s1_valid_d = in_ready_o ? accept : s1_valid_q;
    out_valid_d = s1_adv ? s1_valid_q : out_valid_q;

    out_d.status        = meta_q.status;
    out_d.out_sensor_id = meta_q.hit ? rd_rec.sensor_id : '0;
    out_d.out_timestamp = meta_q.hit ? rd_rec.timestamp : '0;
    out_d.out_value     = meta_q.hit ? rd_rec.value : '0;
    out_d.occupancy     = meta_q.occupancy;
    out_d.unread_first  = meta_q.unread_first;
    out_d.unread_second = meta_q.unread_second;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (accept) meta_q <= meta;
    if (s1_adv && s1_valid_q) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_stall_holds_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> s1_valid_q)
    else $error("stage 1 beat lost under stall");

  a_no_accept_when_full_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("beat taken while both stages are blocked");

  a_read_only_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |=> (s1_valid_q && meta_q.hit && meta_q.status == ST_OK))
    else $error("store read without a matching hit in stage 1");

endmodule
